@@ src/qks_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qks_pkg
// shared types and constants of the quicksort key sorter
// ----------------------------------------------------------------------------
package qks_pkg;

   localparam int MAX_ITEMS_DEFAULT = 64;
   localparam int KEY_W             = 31;
   localparam int IDX_W             = 6;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             is_last;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] sorted_key;
      logic [IDX_W-1:0] origin_index;
      logic             final_result;
      logic             overflow;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [IDX_W-1:0] idx;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_POP,
      ST_LOAD,
      ST_PIVRD,
      ST_PIV,
      ST_RD,
      ST_CMP,
      ST_SWAP,
      ST_PUSH_HI,
      ST_PUSH_LO,
      ST_OUT_RD,
      ST_OUT_LD
   } state_type;

endpackage

@@ src/qks_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qks_store
// key and arrival position memory, one write port and two registered reads
// ----------------------------------------------------------------------------
module qks_store
   import qks_pkg::*;
#(
   parameter int DEPTH = MAX_ITEMS_DEFAULT,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic [AW-1:0] rd_a_addr,
   input  logic [AW-1:0] rd_b_addr,
   output entry_type     rd_a_data,
   output entry_type     rd_b_data
);

   entry_type mem [DEPTH];
   entry_type rd_a_ff;
   entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

@@ src/quicksort_key_sorter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quicksort_key_sorter
// batch sorter: keys load one per cycle, an in-place lomuto quicksort runs
// over the key memory with a range stack, then the batch streams out
// ----------------------------------------------------------------------------
// load: one key per cycle; the sort starts on the transaction marked last
// partition of a range: pivot read, then each key read, compared and swapped
// below the pivot, then sub-range pushes; about N log N memory steps per batch
// output: each result is read once the response slot is free, then registered
// reset clears control and counts; the memories hold garbage until written
module quicksort_key_sorter
   import qks_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int SW = 2 * AW;

   state_type state_ff, state_in;

   logic [CW-1:0]    count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [CW-1:0]    top_ff, top_in;
   logic [AW-1:0]    lo_ff, lo_in;
   logic [AW-1:0]    hi_ff, hi_in;
   logic [AW-1:0]    j_ff, j_in;
   logic [AW-1:0]    fill_ff, fill_in;
   logic [AW-1:0]    k_ff, k_in;
   logic [KEY_W-1:0] pivot_ff, pivot_in;
   logic             final_ff, final_in;
   entry_type        hold_ff, hold_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic            mem_we;
   logic [AW-1:0]   mem_wa;
   entry_type       mem_wd;
   logic [AW-1:0]   mem_ra;
   logic [AW-1:0]   mem_rb;
   entry_type       rd_a;
   entry_type       rd_b;

   logic [SW-1:0]   stack_mem [MAX_ITEMS];
   logic [SW-1:0]   stk_rd_ff;
   logic            stk_we;
   logic [AW-1:0]   stk_wa;
   logic [SW-1:0]   stk_wd;
   logic [AW-1:0]   stk_ra;

   logic            req_fire;
   logic            rsp_free;
   logic            swap;
   logic            push_hi;
   logic            push_lo;
   logic            room;
   logic            out_last;

   qks_store #(
      .DEPTH(MAX_ITEMS)
   ) u_store (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_wa),
      .wr_data   (mem_wd),
      .rd_a_addr (mem_ra),
      .rd_b_addr (mem_rb),
      .rd_a_data (rd_a),
      .rd_b_data (rd_b)
   );

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_wa] <= stk_wd;
      end
      stk_rd_ff <= stack_mem[stk_ra];
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign swap      = final_ff || (rd_a.key < pivot_ff);
   assign room      = (top_ff < CW'(MAX_ITEMS));
   assign push_hi   = ({1'b0, fill_ff} + (AW+1)'(1) < {1'b0, hi_ff});
   assign push_lo   = ({1'b0, fill_ff} > {1'b0, lo_ff} + (AW+1)'(1));
   assign out_last  = (CW'(k_ff) + CW'(1) == count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_data.is_last) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = (count_ff < CW'(2)) ? ST_OUT_RD : ST_PIVRD;
         end
         ST_POP:     state_in = ST_LOAD;
         ST_LOAD:    state_in = ST_PIVRD;
         ST_PIVRD:   state_in = ST_PIV;
         ST_PIV:     state_in = ST_RD;
         ST_RD:      state_in = ST_CMP;
         ST_CMP:     state_in = swap ? ST_SWAP : ST_RD;
         ST_SWAP:    state_in = final_ff ? ST_PUSH_HI : ST_RD;
         ST_PUSH_HI: state_in = ST_PUSH_LO;
         ST_PUSH_LO: begin
            if ((push_lo && room) || (top_ff != '0)) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_OUT_RD;
            end
         end
         ST_OUT_RD: begin
            if (rsp_free) begin
               state_in = ST_OUT_LD;
            end
         end
         ST_OUT_LD:  state_in = out_last ? ST_IDLE : ST_OUT_RD;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      top_in       = top_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      j_in         = j_ff;
      fill_in      = fill_ff;
      k_in         = k_ff;
      pivot_in     = pivot_ff;
      final_in     = final_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_wa       = j_ff;
      mem_wd       = rd_a;
      mem_ra       = j_ff;
      mem_rb       = fill_ff;
      stk_we       = 1'b0;
      stk_wa       = top_ff[AW-1:0];
      stk_wd       = {lo_ff, hi_ff};
      stk_ra       = top_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (count_ff < CW'(MAX_ITEMS)) begin
                  mem_we       = 1'b1;
                  mem_wa       = count_ff[AW-1:0];
                  mem_wd.key   = req_data.key;
                  mem_wd.idx   = IDX_W'(count_ff);
                  count_in     = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ST_START: begin
            k_in   = '0;
            top_in = '0;
            lo_in  = '0;
            hi_in  = AW'(count_ff - CW'(1));
         end
         ST_POP: begin
            stk_ra = AW'(top_ff - CW'(1));
            top_in = top_ff - CW'(1);
         end
         ST_LOAD: begin
            lo_in = stk_rd_ff[SW-1:AW];
            hi_in = stk_rd_ff[AW-1:0];
         end
         ST_PIVRD: begin
            mem_ra = hi_ff;
         end
         ST_PIV: begin
            pivot_in = rd_a.key;
            j_in     = lo_ff;
            fill_in  = lo_ff;
         end
         ST_RD: begin
            final_in = (j_ff == hi_ff);
            mem_ra   = j_ff;
            mem_rb   = fill_ff;
         end
         ST_CMP: begin
            if (swap) begin
               mem_we  = 1'b1;
               mem_wa  = fill_ff;
               mem_wd  = rd_a;
               hold_in = rd_b;
               if (!final_ff) begin
                  fill_in = fill_ff + AW'(1);
               end
            end else begin
               j_in = j_ff + AW'(1);
            end
         end
         ST_SWAP: begin
            mem_we = 1'b1;
            mem_wa = j_ff;
            mem_wd = hold_ff;
            if (!final_ff) begin
               j_in = j_ff + AW'(1);
            end
         end
         ST_PUSH_HI: begin
            if (push_hi && room) begin
               stk_we = 1'b1;
               stk_wd = {fill_ff + AW'(1), hi_ff};
               top_in = top_ff + CW'(1);
            end
         end
         ST_PUSH_LO: begin
            if (push_lo && room) begin
               stk_we = 1'b1;
               stk_wd = {lo_ff, fill_ff - AW'(1)};
               top_in = top_ff + CW'(1);
            end
         end
         ST_OUT_RD: begin
            mem_ra = k_ff;
         end
         ST_OUT_LD: begin
            rsp_valid_in        = 1'b1;
            rsp_in.sorted_key   = rd_a.key;
            rsp_in.origin_index = rd_a.idx;
            rsp_in.final_result = out_last;
            rsp_in.overflow     = ovf_ff;
            if (out_last) begin
               count_in = '0;
               ovf_in   = 1'b0;
            end else begin
               k_in = k_ff + AW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      j_ff     <= j_in;
      fill_ff  <= fill_in;
      k_ff     <= k_in;
      pivot_ff <= pivot_in;
      final_ff <= final_in;
      hold_ff  <= hold_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ bench/tb_quicksort_key_sorter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quicksort_key_sorter
// self-checking bench for the quicksort key sorter: batches of keys go in
// through the request channel, and a local lomuto quicksort with a range stack
// predicts every sorted key, its arrival position and the end and overflow
// flags. Each rsp transaction is compared field by field with the oldest
// prediction. Both sides idle at random, the receiver holds off for a long
// stretch once, and batches cover single keys, duplicates, ordered runs, full
// capacity and dropped keys.
// ----------------------------------------------------------------------------
module tb_quicksort_key_sorter;
   import qks_pkg::*;

   localparam int MAX_ITEMS    = MAX_ITEMS_DEFAULT;
   localparam int KEY_HIGH     = 1231235959;
   localparam int MAX_GAP      = 16;
   localparam int LONG_HOLD    = 400;
   localparam int SETTLE       = 40;
   localparam int RANDOM_ITEMS = 50;

   typedef enum int {
      KEYS_FULL,
      KEYS_NARROW,
      KEYS_RISING,
      KEYS_FALLING
   } key_mode_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // local copy of the batch being collected
   logic [KEY_W-1:0] held_key [MAX_ITEMS];
   logic [IDX_W-1:0] held_pos [MAX_ITEMS];
   int               held_count   = 0;
   bit               held_dropped = 1'b0;

   rsp_type sorted_expect [$];
   int      mismatch_count = 0;
   int      items_sent     = 0;
   int      hold_request   = 0;
   bit      quiet_req      = 1'b0;
   bit      quiet_rsp      = 1'b0;

   quicksort_key_sorter #(
      .MAX_ITEMS(MAX_ITEMS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void swap_held(input int a, input int b);
      logic [KEY_W-1:0] tk;
      logic [IDX_W-1:0] tp;
      tk = held_key[a];
      tp = held_pos[a];
      held_key[a] = held_key[b];
      held_pos[a] = held_pos[b];
      held_key[b] = tk;
      held_pos[b] = tp;
   endfunction

   // lomuto quicksort, last element as pivot, explicit range stack
   function automatic void sort_held();
      int               lo_stack [MAX_ITEMS];
      int               hi_stack [MAX_ITEMS];
      int               top;
      int               lo;
      int               hi;
      int               fill;
      logic [KEY_W-1:0] pivot;
      if (held_count < 2) return;
      lo_stack[0] = 0;
      hi_stack[0] = held_count - 1;
      top = 1;
      while (top > 0) begin
         top--;
         lo = lo_stack[top];
         hi = hi_stack[top];
         pivot = held_key[hi];
         fill = lo;
         for (int j = lo; j < hi; j++) begin
            if (held_key[j] < pivot) begin
               swap_held(fill, j);
               fill++;
            end
         end
         swap_held(fill, hi);
         if (fill + 1 < hi && top < MAX_ITEMS) begin
            lo_stack[top] = fill + 1;
            hi_stack[top] = hi;
            top++;
         end
         if (fill > lo + 1 && top < MAX_ITEMS) begin
            lo_stack[top] = lo;
            hi_stack[top] = fill - 1;
            top++;
         end
      end
   endfunction

   function automatic void collect_key(input logic [KEY_W-1:0] key, input logic last);
      rsp_type r;
      if (held_count < MAX_ITEMS) begin
         held_key[held_count] = key;
         held_pos[held_count] = IDX_W'(held_count);
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (last) begin
         sort_held();
         for (int k = 0; k < held_count; k++) begin
            r.sorted_key   = held_key[k];
            r.origin_index = held_pos[k];
            r.final_result = (k + 1 == held_count);
            r.overflow     = held_dropped;
            sorted_expect.insert(sorted_expect.size(), r);
         end
         held_count   = 0;
         held_dropped = 1'b0;
      end
   endfunction

   task automatic send_key(input logic [KEY_W-1:0] key, input logic last);
      int gap;
      gap = quiet_req ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= '{key: key, is_last: last};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      collect_key(key, last);
      items_sent++;
   endtask

   task automatic send_batch(input int count, input key_mode_type mode);
      logic [KEY_W-1:0] key;
      int               base;
      base = $urandom_range(0, KEY_HIGH / 2);
      for (int k = 0; k < count; k++) begin
         case (mode)
            KEYS_NARROW:  key = KEY_W'($urandom_range(0, 7));
            KEYS_RISING:  key = KEY_W'(base + k * 64 + $urandom_range(0, 40));
            KEYS_FALLING: key = KEY_W'(base + (count - k) * 64 + $urandom_range(0, 40));
            default:      key = KEY_W'($urandom_range(0, KEY_HIGH));
         endcase
         send_key(key, k == count - 1);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sorted_expect.size() != 0) @(posedge clock);
   endtask

   // receiver: random stalls per transaction, one long hold on request
   initial begin : receiver
      int      stall;
      rsp_type want;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
         end else begin
            stall = quiet_rsp ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (sorted_expect.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected rsp transaction: key %0d index %0d final %0b ovf %0b",
                        rsp_data.sorted_key, rsp_data.origin_index,
                        rsp_data.final_result, rsp_data.overflow);
         end else begin
            want = sorted_expect.pop_front();
            if (rsp_data.sorted_key !== want.sorted_key ||
                rsp_data.origin_index !== want.origin_index ||
                rsp_data.final_result !== want.final_result ||
                rsp_data.overflow !== want.overflow) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: exp key %0d index %0d final %0b ovf %0b, ",
                            "got key %0d index %0d final %0b ovf %0b"},
                           want.sorted_key, want.origin_index, want.final_result,
                           want.overflow, rsp_data.sorted_key, rsp_data.origin_index,
                           rsp_data.final_result, rsp_data.overflow);
            end
         end
      end
   end

   task automatic test_single_key();
      send_key('0, 1'b1);
      send_key(KEY_W'(KEY_HIGH), 1'b1);
   endtask

   task automatic test_extreme_keys();
      send_key(KEY_W'(KEY_HIGH), 1'b0);
      send_key('0, 1'b0);
      send_key(KEY_W'(KEY_HIGH), 1'b0);
      send_key('0, 1'b0);
      send_key(KEY_W'(32'h2AAA_AAAA), 1'b0);
      send_key(KEY_W'(32'h1555_5555), 1'b1);
   endtask

   task automatic test_equal_keys();
      for (int k = 0; k < 4; k++) send_key(KEY_W'(1010101010), k == 3);
   endtask

   task automatic test_ordered_runs();
      send_batch(5, KEYS_RISING);
      send_batch(5, KEYS_FALLING);
   endtask

   // full batch, then keys beyond capacity including the one marked last
   task automatic test_overflow();
      wait_drained();
      send_batch(MAX_ITEMS, KEYS_FULL);
      send_batch(MAX_ITEMS + 2, KEYS_FULL);
   endtask

   task automatic test_backpressure();
      wait_drained();
      quiet_req = 1'b1;
      hold_request = LONG_HOLD;
      send_batch(8, KEYS_FULL);
      send_batch(8, KEYS_NARROW);
      send_batch(3, KEYS_FULL);
      quiet_req = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_batches();
      int           first;
      int           pick;
      int           count;
      key_mode_type mode;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)     count = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
         else if (pick < 4) count = $urandom_range(13, MAX_ITEMS);
         else               count = $urandom_range(1, 12);
         mode = key_mode_type'($urandom_range(0, 3));
         quiet_req = ($urandom_range(0, 3) == 0);
         quiet_rsp = ($urandom_range(0, 3) == 0);
         send_batch(count, mode);
         if ($urandom_range(0, 3) == 0) wait_drained();
      end
      quiet_req = 1'b0;
      quiet_rsp = 1'b0;
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_key();
      test_extreme_keys();
      test_equal_keys();
      test_ordered_runs();
      test_overflow();
      test_backpressure();
      test_random_batches();
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0 && sorted_expect.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ files.f @@
src/qks_pkg.sv
src/qks_store.sv
src/quicksort_key_sorter.sv
bench/tb_quicksort_key_sorter.sv
